[hw/rtl/rtpma_pkg.sv]
// Shared constants, stage payload type and arctangent table for the
// rectangular-to-polar converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtpma_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int CORDIC_STEPS   = 16;
   localparam int GUARD_BITS     = 8;

   // |coord| needs the full field width to hold 2^(COORD_WIDTH-1)
   localparam int ABS_WIDTH      = COORD_WIDTH;
   // sign bit plus headroom for CORDIC growth (about 2.33x worst case)
   localparam int DP_WIDTH       = COORD_WIDTH + GUARD_BITS + 3;
   // angle accumulator, degrees in Q16, signed
   localparam int Z_WIDTH        = 25;
   localparam int STEP_IDX_WIDTH = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int TABLE_LEN      = 24;
   localparam int TBL_IDX_WIDTH  = $clog2(TABLE_LEN);

   // reciprocal of the CORDIC gain in Q30, with the finite step correction
   localparam int GAIN_WIDTH     = 30;
   localparam logic [63:0] GAIN_FULL = 64'd652032874
      + ((64'd434688583 + (64'd1 << (2 * CORDIC_STEPS - 1))) >> (2 * CORDIC_STEPS));
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = GAIN_FULL[GAIN_WIDTH-1:0];

   localparam int XF_WIDTH       = DP_WIDTH - 1;
   localparam int PROD_WIDTH     = XF_WIDTH + GAIN_WIDTH;
   localparam int ROUND_WIDTH    = PROD_WIDTH + 1;
   localparam int MAG_SHIFT      = 34;
   localparam int MAGF_WIDTH     = ROUND_WIDTH - MAG_SHIFT;
   localparam int MAG_WIDTH      = 20;

   localparam int ANGLE_WIDTH    = 15;
   localparam int ANGLE_MAX      = 23040;
   localparam int ANGLE_DROP     = 8;
   localparam int ZS_WIDTH       = Z_WIDTH + 1 - ANGLE_DROP;

   typedef struct packed {
      logic signed [DP_WIDTH-1:0] x;
      logic signed [DP_WIDTH-1:0] y;
      logic signed [Z_WIDTH-1:0]  z;
      logic                       ax_zero;
      logic                       ay_zero;
   } vec_type;

   // round(atan(2^-i) * 180/pi * 2^16)
   function automatic logic [Z_WIDTH-1:0] atan_q16(input logic [TBL_IDX_WIDTH-1:0] idx);
      logic [Z_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = Z_WIDTH'(2949120);
         5'd1:    val = Z_WIDTH'(1740967);
         5'd2:    val = Z_WIDTH'(919879);
         5'd3:    val = Z_WIDTH'(466945);
         5'd4:    val = Z_WIDTH'(234379);
         5'd5:    val = Z_WIDTH'(117304);
         5'd6:    val = Z_WIDTH'(58666);
         5'd7:    val = Z_WIDTH'(29335);
         5'd8:    val = Z_WIDTH'(14668);
         5'd9:    val = Z_WIDTH'(7334);
         5'd10:   val = Z_WIDTH'(3667);
         5'd11:   val = Z_WIDTH'(1833);
         5'd12:   val = Z_WIDTH'(917);
         5'd13:   val = Z_WIDTH'(458);
         5'd14:   val = Z_WIDTH'(229);
         5'd15:   val = Z_WIDTH'(115);
         5'd16:   val = Z_WIDTH'(57);
         5'd17:   val = Z_WIDTH'(29);
         5'd18:   val = Z_WIDTH'(14);
         5'd19:   val = Z_WIDTH'(7);
         5'd20:   val = Z_WIDTH'(4);
         5'd21:   val = Z_WIDTH'(2);
         5'd22:   val = Z_WIDTH'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rect_to_polar_magnitude_angle.sv]
// Top level of the rectangular-to-polar converter: input fold, unrolled
// CORDIC vectoring pipeline, gain and rounding. Depends on rtpma_pkg,
// rtpma_prep, rtpma_cordic_stage and rtpma_post.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_ready, req_coord_x/y     | in
//  rsp     | rsp_valid, rsp_ready, rsp_magnitude,    | out
//          | rsp_angle_deg                           |
//
// One transaction enters per cycle while the output is not stalled; the
// pipeline holds one fold stage, one stage per micro-rotation, the gain
// multiply stage and the result register. Every stage holds its own valid
// bit, so bubbles close up under backpressure and a stall drops nothing.
// Synchronous reset clears the valid bits only; there is no carried state.
`timescale 1ns / 1ps
`default_nettype none

module rect_to_polar_magnitude_angle (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic signed [rtpma_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  wire logic signed [rtpma_pkg::COORD_WIDTH-1:0] req_coord_y,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic [rtpma_pkg::MAG_WIDTH-1:0]               rsp_magnitude,
   output logic [rtpma_pkg::ANGLE_WIDTH-1:0]             rsp_angle_deg
);

   rtpma_pkg::vec_type                     stage_data  [rtpma_pkg::CORDIC_STEPS+1];
   logic [rtpma_pkg::CORDIC_STEPS:0]       stage_valid;
   logic [rtpma_pkg::CORDIC_STEPS:0]       stage_ready;

   rtpma_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .coord_x   (req_coord_x),
      .coord_y   (req_coord_y),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar s = 0; s < rtpma_pkg::CORDIC_STEPS; s++) begin : g_step
      rtpma_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (rtpma_pkg::STEP_IDX_WIDTH'(s)),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_data   (stage_data[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_data  (stage_data[s+1])
      );
   end

   rtpma_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[rtpma_pkg::CORDIC_STEPS]),
      .in_ready  (stage_ready[rtpma_pkg::CORDIC_STEPS]),
      .in_data   (stage_data[rtpma_pkg::CORDIC_STEPS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .magnitude (rsp_magnitude),
      .angle_deg (rsp_angle_deg)
   );

endmodule

`default_nettype wire

[hw/rtl/rtpma_prep.sv]
// Input stage: folds both components into the first quadrant and
// scales them up by the guard bits. Depends on rtpma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpma_prep (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   output logic                                          in_ready,
   input  wire logic signed [rtpma_pkg::COORD_WIDTH-1:0] coord_x,
   input  wire logic signed [rtpma_pkg::COORD_WIDTH-1:0] coord_y,
   output logic                                          out_valid,
   input  wire logic                                     out_ready,
   output rtpma_pkg::vec_type                            out_data
);

   logic                          valid_ff;
   logic                          valid_in;
   rtpma_pkg::vec_type            data_ff;
   rtpma_pkg::vec_type            data_in;
   logic [rtpma_pkg::ABS_WIDTH-1:0] abs_x;
   logic [rtpma_pkg::ABS_WIDTH-1:0] abs_y;

   // two's complement negate; the most negative code maps to 2^(W-1) unsigned
   assign abs_x = coord_x[rtpma_pkg::COORD_WIDTH-1] ? (~coord_x + 1'b1) : coord_x;
   assign abs_y = coord_y[rtpma_pkg::COORD_WIDTH-1] ? (~coord_y + 1'b1) : coord_y;

   always_comb begin
      data_in.x       = rtpma_pkg::DP_WIDTH'({abs_x, {rtpma_pkg::GUARD_BITS{1'b0}}});
      data_in.y       = rtpma_pkg::DP_WIDTH'({abs_y, {rtpma_pkg::GUARD_BITS{1'b0}}});
      data_in.z       = '0;
      data_in.ax_zero = (abs_x == '0);
      data_in.ay_zero = (abs_y == '0);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[hw/rtl/rtpma_cordic_stage.sv]
// One vectoring micro-rotation with its own register stage.
// The step index is tied to a constant per instance. Depends on rtpma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpma_cordic_stage (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [rtpma_pkg::STEP_IDX_WIDTH-1:0]  stage_idx,
   input  wire logic                                  in_valid,
   output logic                                       in_ready,
   input  wire rtpma_pkg::vec_type                    in_data,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output rtpma_pkg::vec_type                         out_data
);

   logic                                  valid_ff;
   logic                                  valid_in;
   rtpma_pkg::vec_type                    data_ff;
   rtpma_pkg::vec_type                    data_in;
   logic signed [rtpma_pkg::DP_WIDTH-1:0] x_cur;
   logic signed [rtpma_pkg::DP_WIDTH-1:0] y_cur;
   logic signed [rtpma_pkg::DP_WIDTH-1:0] dx;
   logic signed [rtpma_pkg::DP_WIDTH-1:0] dy;
   logic [rtpma_pkg::Z_WIDTH-1:0]         step_angle;

   always_comb begin
      x_cur      = in_data.x;
      y_cur      = in_data.y;
      // arithmetic shift rounds toward minus infinity
      dx         = y_cur >>> stage_idx;
      dy         = x_cur >>> stage_idx;
      step_angle = rtpma_pkg::atan_q16(rtpma_pkg::TBL_IDX_WIDTH'(stage_idx));
      data_in    = in_data;
      if (y_cur > 0) begin
         data_in.x = x_cur + dx;
         data_in.y = y_cur - dy;
         data_in.z = in_data.z + $signed(step_angle);
      end else begin
         data_in.x = x_cur - dx;
         data_in.y = y_cur + dy;
         data_in.z = in_data.z - $signed(step_angle);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[hw/rtl/rtpma_post.sv]
// Output end: gain multiply in one stage, then rounding, saturation and
// the angle fold into the result register. Depends on rtpma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpma_post (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire rtpma_pkg::vec_type                     in_data,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic [rtpma_pkg::MAG_WIDTH-1:0]             magnitude,
   output logic [rtpma_pkg::ANGLE_WIDTH-1:0]           angle_deg
);

   // multiply stage
   logic                                   mul_valid_ff;
   logic                                   mul_valid_in;
   logic                                   mul_ready;
   logic [rtpma_pkg::PROD_WIDTH-1:0]       prod_ff;
   logic [rtpma_pkg::PROD_WIDTH-1:0]       prod_in;
   logic signed [rtpma_pkg::Z_WIDTH-1:0]   z_ff;
   logic                                   ax_zero_ff;
   logic                                   ay_zero_ff;
   logic signed [rtpma_pkg::DP_WIDTH-1:0]  x_cur;
   logic [rtpma_pkg::XF_WIDTH-1:0]         x_pos;

   // result stage
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic                                   rsp_load;
   logic [rtpma_pkg::MAG_WIDTH-1:0]        mag_ff;
   logic [rtpma_pkg::MAG_WIDTH-1:0]        mag_in;
   logic [rtpma_pkg::ANGLE_WIDTH-1:0]      ang_ff;
   logic [rtpma_pkg::ANGLE_WIDTH-1:0]      ang_in;
   logic [rtpma_pkg::ROUND_WIDTH-1:0]      mag_sum;
   logic [rtpma_pkg::MAGF_WIDTH-1:0]       mag_full;
   logic [rtpma_pkg::Z_WIDTH-1:0]          z_pos;
   logic [rtpma_pkg::Z_WIDTH:0]            z_round;
   logic [rtpma_pkg::ZS_WIDTH-1:0]         z_scaled;

   always_comb begin
      x_cur   = in_data.x;
      x_pos   = (x_cur > 0) ? x_cur[rtpma_pkg::XF_WIDTH-1:0] : '0;
      prod_in = rtpma_pkg::PROD_WIDTH'(x_pos) * rtpma_pkg::PROD_WIDTH'(rtpma_pkg::GAIN_Q30);
   end

   assign rsp_load     = !rsp_valid_ff || out_ready;
   assign mul_ready    = !mul_valid_ff || rsp_load;
   assign in_ready     = mul_ready;
   assign mul_valid_in = mul_ready ? in_valid : mul_valid_ff;
   assign rsp_valid_in = rsp_load ? mul_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && mul_ready) begin
         prod_ff    <= prod_in;
         z_ff       <= in_data.z;
         ax_zero_ff <= in_data.ax_zero;
         ay_zero_ff <= in_data.ay_zero;
      end
   end

   always_comb begin
      // round to nearest: (P + 2^33) >> 34
      mag_sum  = {1'b0, prod_ff}
               + (rtpma_pkg::ROUND_WIDTH'(1) << (rtpma_pkg::MAG_SHIFT - 1));
      mag_full = mag_sum[rtpma_pkg::ROUND_WIDTH-1:rtpma_pkg::MAG_SHIFT];
      if (rtpma_pkg::ROUND_WIDTH'(mag_full)
          > rtpma_pkg::ROUND_WIDTH'((64'd1 << rtpma_pkg::MAG_WIDTH) - 64'd1)) begin
         mag_in = '1;
      end else begin
         mag_in = rtpma_pkg::MAG_WIDTH'(mag_full);
      end

      z_pos    = z_ff[rtpma_pkg::Z_WIDTH-1] ? '0 : z_ff;
      z_round  = {1'b0, z_pos} + (rtpma_pkg::Z_WIDTH + 1)'(1 << (rtpma_pkg::ANGLE_DROP - 1));
      z_scaled = z_round[rtpma_pkg::Z_WIDTH:rtpma_pkg::ANGLE_DROP];

      // vertical zero wins (covers the zero vector), then horizontal zero
      if (ay_zero_ff) begin
         ang_in = '0;
      end else if (ax_zero_ff) begin
         ang_in = rtpma_pkg::ANGLE_WIDTH'(rtpma_pkg::ANGLE_MAX);
      end else if (z_scaled > rtpma_pkg::ZS_WIDTH'(rtpma_pkg::ANGLE_MAX)) begin
         ang_in = rtpma_pkg::ANGLE_WIDTH'(rtpma_pkg::ANGLE_MAX);
      end else begin
         ang_in = rtpma_pkg::ANGLE_WIDTH'(z_scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && mul_valid_ff) begin
         mag_ff <= mag_in;
         ang_ff <= ang_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign magnitude = mag_ff;
   assign angle_deg = ang_ff;

endmodule

`default_nettype wire

[hw/rtl/rtpma_checker.sv]
// Port-level checks for the rectangular-to-polar converter, bound to the
// top level. Depends on rtpma_pkg and rect_to_polar_magnitude_angle.
`timescale 1ns / 1ps
`default_nettype none

module rtpma_checker (
   input wire logic                                     clock,
   input wire logic                                     reset,
   input wire logic                                     req_valid,
   input wire logic                                     req_ready,
   input wire logic signed [rtpma_pkg::COORD_WIDTH-1:0] req_coord_x,
   input wire logic signed [rtpma_pkg::COORD_WIDTH-1:0] req_coord_y,
   input wire logic                                     rsp_valid,
   input wire logic                                     rsp_ready,
   input wire logic [rtpma_pkg::MAG_WIDTH-1:0]          rsp_magnitude,
   input wire logic [rtpma_pkg::ANGLE_WIDTH-1:0]        rsp_angle_deg
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_magnitude)
                                   && $stable(rsp_angle_deg))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // input backpressure only when the pipe is full and the output blocked
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low with free pipeline space");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_deg <= rtpma_pkg::ANGLE_WIDTH'(rtpma_pkg::ANGLE_MAX))
      else $error("angle above 90 degrees");

   // only the zero vector has zero length, and its angle is zero
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_magnitude == '0 |-> rsp_angle_deg == '0)
      else $error("zero length with nonzero angle");

endmodule

bind rect_to_polar_magnitude_angle rtpma_checker u_rtpma_checker (.*);

`default_nettype wire
